// ===== rtl/core/crt_congruence_sync_core_defines.svh =====
// assertion helpers used by crtcs_dpath
`ifndef CRT_CONGRUENCE_SYNC_CORE_DEFINES_SVH
`define CRT_CONGRUENCE_SYNC_CORE_DEFINES_SVH

// same-cycle implication
`define CRTCS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CRTCS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/crtcs_pkg.sv =====
`timescale 1ns / 1ps
package crtcs_pkg;

   localparam int SYNC_BITS = 63;

   localparam logic [7:0] CH_A   = 8'h61;
   localparam logic [7:0] CH_Z   = 8'h7a;
   localparam logic [7:0] CH_BAR = 8'h7c;
   localparam logic [7:0] CH_NL  = 8'h0a;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD     = 2'd1,
      ST_UNREACH = 2'd2,
      ST_OVF     = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CHAR, OP_CLOSE, OP_R2, OP_GCD, OP_RG1, OP_RG2, OP_M1G,
      OP_OVF, OP_N, OP_R1M, OP_DG, OP_DN, OP_INV0, OP_EUCQ, OP_EUCT,
      OP_KR, OP_FIN, OP_EMIT
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_R2_WAIT, S_GCD_WAIT, S_RG1_WAIT, S_RG2_WAIT, S_M1G_WAIT,
      S_OVF_WAIT, S_N_WAIT, S_R1M_WAIT, S_DG_WAIT, S_DN_WAIT, S_INV_WAIT,
      S_EUCD_WAIT, S_EUCM_WAIT, S_K_WAIT, S_FIN_WAIT, S_EMIT
   } state_type;

   typedef struct packed {
      logic sticky_ok;
      logic line_open;
      logic per_lt2;
      logic have;
      logic div_done;
      logic mul_done;
      logic rem_zero;
      logic mismatch;
      logic prod_ovf;
      logic rsp_full;
   } flags_type;

endpackage

// ===== rtl/core/crtcs_div.sv =====
`timescale 1ns / 1ps
module crtcs_div
   import crtcs_pkg::*;
#(
   parameter int W = 63
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder,
   output logic         done
);
   localparam int CW = (W > 1) ? $clog2(W) : 1;

   logic          busy_ff, done_ff;
   logic [CW-1:0] cnt_ff;
   logic [W-1:0]  quo_ff, rem_ff, dvs_ff;
   logic [W:0]    trial, diff;
   logic          ge;

   // restoring divider, one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[W-1]};
      diff  = trial - {1'b0, dvs_ff};
      ge    = (trial >= {1'b0, dvs_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[W-1:0] : trial[W-1:0];
            quo_ff <= {quo_ff[W-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;
endmodule

// ===== rtl/core/crtcs_mul.sv =====
`timescale 1ns / 1ps
module crtcs_mul
   import crtcs_pkg::*;
#(
   parameter int W = 63
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           mod_mode,
   input  logic [W-1:0]   a,
   input  logic [W-1:0]   b,
   input  logic [W-1:0]   m,
   output logic [2*W-1:0] prod,
   output logic           done
);
   localparam int CW = (W > 1) ? $clog2(W) : 1;

   logic           busy_ff, done_ff, mode_ff;
   logic [CW-1:0]  cnt_ff;
   logic [2*W-1:0] a_ff, p_ff, m_wide, sum, dbl, p_in, a_in;
   logic [W-1:0]   b_ff, m_ff;

   // shift-add; in modular mode both the partial sum and the doubled
   // operand stay below m
   always_comb begin
      m_wide = {{W{1'b0}}, m_ff};
      sum    = p_ff + (b_ff[0] ? a_ff : '0);
      dbl    = {a_ff[2*W-2:0], 1'b0};
      p_in   = (mode_ff && sum >= m_wide) ? sum - m_wide : sum;
      a_in   = (mode_ff && dbl >= m_wide) ? dbl - m_wide : dbl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            mode_ff <= mod_mode;
            a_ff    <= {{W{1'b0}}, a};
            b_ff    <= b;
            m_ff    <= m;
            p_ff    <= '0;
         end else if (busy_ff) begin
            p_ff   <= p_in;
            a_ff   <= a_in;
            b_ff   <= b_ff >> 1;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign prod = p_ff;
   assign done = done_ff;
endmodule

// ===== rtl/core/crtcs_ctrl.sv =====
`timescale 1ns / 1ps
module crtcs_ctrl
   import crtcs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic [7:0] req_ch,
   input  logic      req_end_stream,
   output logic      req_stall,
   input  flags_type flags,
   output op_type    op
);
   state_type state_ff, state_in, fin_state;
   logic      pend_ff, pend_in, accept, closing;

   assign req_stall = (state_ff != S_IDLE) || (flags.rsp_full && req_end_stream);
   assign accept    = req_valid && !req_stall;
   assign fin_state = pend_ff ? S_EMIT : S_IDLE;
   assign closing   = req_end_stream ? (flags.sticky_ok && flags.line_open)
                                     : (flags.sticky_ok && req_ch == CH_NL);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (closing)
                  state_in = flags.per_lt2 ? (req_end_stream ? S_EMIT : S_IDLE)
                                           : S_R2_WAIT;
               else if (req_end_stream)
                  state_in = S_EMIT;
            end
         end
         S_R2_WAIT:   if (flags.div_done) state_in = flags.have ? S_GCD_WAIT : fin_state;
         S_GCD_WAIT:  if (flags.div_done && flags.rem_zero) state_in = S_RG1_WAIT;
         S_RG1_WAIT:  if (flags.div_done) state_in = S_RG2_WAIT;
         S_RG2_WAIT:  if (flags.div_done) state_in = flags.mismatch ? fin_state : S_M1G_WAIT;
         S_M1G_WAIT:  if (flags.div_done) state_in = S_OVF_WAIT;
         S_OVF_WAIT:  if (flags.mul_done) state_in = flags.prod_ovf ? fin_state : S_N_WAIT;
         S_N_WAIT:    if (flags.div_done) state_in = S_R1M_WAIT;
         S_R1M_WAIT:  if (flags.div_done) state_in = S_DG_WAIT;
         S_DG_WAIT:   if (flags.div_done) state_in = S_DN_WAIT;
         S_DN_WAIT:   if (flags.div_done) state_in = S_INV_WAIT;
         S_INV_WAIT:  if (flags.div_done) state_in = flags.rem_zero ? S_K_WAIT : S_EUCD_WAIT;
         S_EUCD_WAIT: if (flags.div_done) state_in = S_EUCM_WAIT;
         S_EUCM_WAIT: if (flags.mul_done) state_in = flags.rem_zero ? S_K_WAIT : S_EUCD_WAIT;
         S_K_WAIT:    if (flags.mul_done) state_in = S_FIN_WAIT;
         S_FIN_WAIT:  if (flags.mul_done) state_in = fin_state;
         S_EMIT:      state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (closing)
                  op = OP_CLOSE;
               else if (!req_end_stream && flags.sticky_ok)
                  op = OP_CHAR;
            end
         end
         S_R2_WAIT:   if (flags.div_done) op = OP_R2;
         S_GCD_WAIT:  if (flags.div_done) op = OP_GCD;
         S_RG1_WAIT:  if (flags.div_done) op = OP_RG1;
         S_RG2_WAIT:  if (flags.div_done) op = OP_RG2;
         S_M1G_WAIT:  if (flags.div_done) op = OP_M1G;
         S_OVF_WAIT:  if (flags.mul_done) op = OP_OVF;
         S_N_WAIT:    if (flags.div_done) op = OP_N;
         S_R1M_WAIT:  if (flags.div_done) op = OP_R1M;
         S_DG_WAIT:   if (flags.div_done) op = OP_DG;
         S_DN_WAIT:   if (flags.div_done) op = OP_DN;
         S_INV_WAIT:  if (flags.div_done) op = OP_INV0;
         S_EUCD_WAIT: if (flags.div_done) op = OP_EUCQ;
         S_EUCM_WAIT: if (flags.mul_done) op = OP_EUCT;
         S_K_WAIT:    if (flags.mul_done) op = OP_KR;
         S_FIN_WAIT:  if (flags.mul_done) op = OP_FIN;
         S_EMIT:      op = OP_EMIT;
         default:     op = OP_NONE;
      endcase
   end

   assign pend_in = (state_ff == S_IDLE && accept) ? req_end_stream : pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end
endmodule

// ===== rtl/core/crtcs_dpath.sv =====
`timescale 1ns / 1ps
`include "crt_congruence_sync_core_defines.svh"
module crtcs_dpath
   import crtcs_pkg::*;
#(
   parameter int W = 63
) (
   input  logic                 clock,
   input  logic                 reset,
   input  op_type               op,
   input  logic [7:0]           req_ch,
   output flags_type            flags,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [SYNC_BITS-1:0] rsp_sync_time
);
   logic [W-1:0] off_ff, per_ff, acc_r_ff, acc_m_ff;
   logic         bar_ff, lopen_ff, have_ff;
   logic [1:0]   lcnt_ff;
   status_type   sticky_ff;
   logic [W-1:0] m2_ff, r2_ff, ga_ff, g_ff, t_ff, m1g_ff, newm_ff, n_ff, d_ff;
   logic [W-1:0] er1_ff, t0_ff, t1_ff;
   logic         rsp_valid_ff;
   status_type   rsp_status_ff;
   logic [SYNC_BITS-1:0] rsp_time_ff;

   logic           div_start, div_done, mul_start, mul_mode, mul_done;
   logic [W-1:0]   div_a, div_b, quo, rem, mul_a, mul_b, mul_m;
   logic [2*W-1:0] prod;
   logic [W-1:0]   p_lo, dsub, qred, tn, letter, dst;
   logic [W:0]     dst_sum, bar_sum;
   logic           is_letter, prod_ovf;
   status_type     emit_status;

   crtcs_div #(.W(W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(div_b), .quotient(quo), .remainder(rem), .done(div_done)
   );

   crtcs_mul #(.W(W)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .mod_mode(mul_mode),
      .a(mul_a), .b(mul_b), .m(mul_m), .prod(prod), .done(mul_done)
   );

   always_comb begin
      is_letter = (req_ch >= CH_A) && (req_ch <= CH_Z);
      letter    = W'(1) << (5'(req_ch - CH_A));
      dst       = bar_ff ? per_ff : off_ff;
      dst_sum   = {1'b0, dst} + {1'b0, letter};
      bar_sum   = {1'b0, per_ff} + {1'b0, off_ff};
      p_lo      = prod[W-1:0];
      prod_ovf  = |prod[2*W-1:W];
      dsub      = (r2_ff >= rem) ? r2_ff - rem : r2_ff + m2_ff - rem;
      qred      = (quo >= n_ff) ? quo - n_ff : quo;
      tn        = (t0_ff >= p_lo) ? t0_ff - p_lo : t0_ff + n_ff - p_lo;
      emit_status = sticky_ff;
      if (sticky_ff == ST_OK && lcnt_ff != 2'd2)
         emit_status = ST_BAD;
   end

   // operand steering for the shared divider and multiplier
   always_comb begin
      div_start = 1'b0;
      div_a     = '0;
      div_b     = '0;
      mul_start = 1'b0;
      mul_mode  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      mul_m     = '0;
      case (op)
         OP_CLOSE: begin
            div_start = (per_ff[W-1:1] != '0);
            div_a = off_ff;  div_b = per_ff;
         end
         OP_R2: begin
            div_start = have_ff;
            div_a = m2_ff;   div_b = acc_m_ff;
         end
         OP_GCD: begin
            div_start = 1'b1;
            div_a = (rem == '0) ? acc_r_ff : ga_ff;
            div_b = (rem == '0) ? ga_ff : rem;
         end
         OP_RG1: begin
            div_start = 1'b1;
            div_a = r2_ff;   div_b = g_ff;
         end
         OP_RG2: begin
            div_start = (rem == t_ff);
            div_a = acc_m_ff; div_b = g_ff;
         end
         OP_M1G: begin
            mul_start = 1'b1;
            mul_a = quo;     mul_b = m2_ff;
         end
         OP_OVF: begin
            div_start = !prod_ovf;
            div_a = m2_ff;   div_b = g_ff;
         end
         OP_N: begin
            div_start = 1'b1;
            div_a = acc_r_ff; div_b = m2_ff;
         end
         OP_R1M: begin
            div_start = 1'b1;
            div_a = dsub;    div_b = g_ff;
         end
         OP_DG: begin
            div_start = 1'b1;
            div_a = quo;     div_b = n_ff;
         end
         OP_DN: begin
            div_start = 1'b1;
            div_a = m1g_ff;  div_b = n_ff;
         end
         OP_INV0: begin
            if (rem == '0) begin
               mul_start = 1'b1;  mul_mode = 1'b1;
               mul_a = d_ff;  mul_b = '0;  mul_m = n_ff;
            end else begin
               div_start = 1'b1;
               div_a = n_ff;  div_b = rem;
            end
         end
         OP_EUCQ: begin
            mul_start = 1'b1;  mul_mode = 1'b1;
            mul_a = qred;  mul_b = t1_ff;  mul_m = n_ff;
         end
         OP_EUCT: begin
            if (rem == '0) begin
               mul_start = 1'b1;  mul_mode = 1'b1;
               mul_a = d_ff;  mul_b = t1_ff;  mul_m = n_ff;
            end else begin
               div_start = 1'b1;
               div_a = er1_ff;  div_b = rem;
            end
         end
         OP_KR: begin
            mul_start = 1'b1;
            mul_a = acc_m_ff;  mul_b = p_lo;
         end
         default: ;
      endcase
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset || op == OP_EMIT) begin
         off_ff    <= '0;
         per_ff    <= '0;
         bar_ff    <= 1'b0;
         lopen_ff  <= 1'b0;
         sticky_ff <= ST_OK;
         acc_r_ff  <= '0;
         acc_m_ff  <= '0;
         have_ff   <= 1'b0;
         lcnt_ff   <= '0;
      end else begin
         case (op)
            OP_CHAR: begin
               lopen_ff <= 1'b1;
               if (req_ch == CH_BAR) begin
                  if (bar_ff) begin
                     sticky_ff <= ST_BAD;
                  end else begin
                     bar_ff <= 1'b1;
                     per_ff <= bar_sum[W-1:0];
                     if (bar_sum[W]) sticky_ff <= ST_OVF;
                  end
               end else if (is_letter) begin
                  if (dst_sum[W])
                     sticky_ff <= ST_OVF;
                  else if (bar_ff)
                     per_ff <= dst_sum[W-1:0];
                  else
                     off_ff <= dst_sum[W-1:0];
               end else begin
                  sticky_ff <= ST_BAD;
               end
            end
            OP_CLOSE: begin
               off_ff   <= '0;
               per_ff   <= '0;
               bar_ff   <= 1'b0;
               lopen_ff <= 1'b0;
               if (per_ff == '0)
                  sticky_ff <= ST_BAD;
               else if (lcnt_ff != 2'd2)
                  lcnt_ff <= lcnt_ff + 2'd1;
            end
            OP_R2: begin
               if (!have_ff) begin
                  acc_r_ff <= rem;
                  acc_m_ff <= m2_ff;
                  have_ff  <= 1'b1;
               end
            end
            OP_RG2: if (rem != t_ff) sticky_ff <= ST_UNREACH;
            OP_OVF: if (prod_ovf) sticky_ff <= ST_OVF;
            OP_FIN: begin
               acc_r_ff <= acc_r_ff + p_lo;
               acc_m_ff <= newm_ff;
            end
            default: ;
         endcase
      end
   end

   // merge scratch registers
   always_ff @(posedge clock) begin
      case (op)
         OP_CLOSE: m2_ff <= per_ff;
         OP_R2:    begin r2_ff <= rem;  ga_ff <= acc_m_ff; end
         OP_GCD:   begin g_ff <= ga_ff; ga_ff <= rem; end
         OP_RG1:   t_ff <= rem;
         OP_M1G:   m1g_ff <= quo;
         OP_OVF:   newm_ff <= p_lo;
         OP_N:     n_ff <= quo;
         OP_DN:    d_ff <= rem;
         OP_INV0: begin
            er1_ff <= rem;
            t0_ff  <= '0;
            t1_ff  <= W'(1);
         end
         OP_EUCT: begin
            er1_ff <= rem;
            t0_ff  <= t1_ff;
            t1_ff  <= tn;
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (op == OP_EMIT) begin
         rsp_valid_ff  <= 1'b1;
         rsp_status_ff <= emit_status;
         rsp_time_ff   <= (emit_status == ST_OK && have_ff) ? SYNC_BITS'(acc_r_ff) : '0;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_sync_time = rsp_time_ff;

   always_comb begin
      flags.sticky_ok = (sticky_ff == ST_OK);
      flags.line_open = lopen_ff;
      flags.per_lt2   = (per_ff[W-1:1] == '0);
      flags.have      = have_ff;
      flags.div_done  = div_done;
      flags.mul_done  = mul_done;
      flags.rem_zero  = (rem == '0);
      flags.mismatch  = (rem != t_ff);
      flags.prod_ovf  = prod_ovf;
      flags.rsp_full  = rsp_valid_ff;
   end

   `CRTCS_ASSERT_IMPL(a_residue_reduced, have_ff, acc_r_ff < acc_m_ff, "residue not below modulus")
   `CRTCS_ASSERT_NEXT(a_sticky_holds, (sticky_ff != ST_OK) && (op != OP_EMIT), sticky_ff == $past(sticky_ff), "error status changed")
   `CRTCS_ASSERT_IMPL(a_no_overwrite, op == OP_EMIT, !rsp_valid_ff, "result overwritten")
endmodule

// ===== rtl/core/crt_congruence_sync_core.sv =====
`timescale 1ns / 1ps
// line ends and merges run on the shared one-bit-per-cycle divider and shift-add
// multiplier (W = VALUE_BITS-1 bits wide); a merge walks gcd and euclid steps,
// and new beats are stalled until the sequencer is idle again
// end of stream gives one result beat after the pending merge
// synchronous active-high reset clears all sums, flags and the result valid bit
module crt_congruence_sync_core
   import crtcs_pkg::*;
#(
   parameter int VALUE_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_ch,
   input  logic                 req_end_stream,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [SYNC_BITS-1:0] rsp_sync_time
);
   // all values stay at or below 2^(VALUE_BITS-1)-1
   localparam int W = VALUE_BITS - 1;

   flags_type flags;
   op_type    op;

   // sequencer: decodes characters, walks gcd / euclid / merge steps
   crtcs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ch         (req_ch),
      .req_end_stream (req_end_stream),
      .req_stall      (req_stall),
      .flags          (flags),
      .op             (op)
   );

   // sums, accumulated congruence, divider, multiplier and result beat
   crtcs_dpath #(.W(W)) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .req_ch        (req_ch),
      .flags         (flags),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_sync_time (rsp_sync_time)
   );
endmodule

// ===== tb/crt_congruence_sync_core_checker.sv =====
`timescale 1ns / 1ps
module crt_congruence_sync_core_checker
   import crtcs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [7:0]           req_ch,
   input  logic                 req_end_stream,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [1:0]           rsp_status,
   input  logic [SYNC_BITS-1:0] rsp_sync_time,
   output int                   fail_count,
   output int                   pending,
   output int                   status_seen [4]
);

   localparam logic [63:0] VMAX = 64'h7fff_ffff_ffff_ffff;

   typedef struct {
      status_type           st;
      logic [SYNC_BITS-1:0] when;
   } sync_result_type;

   sync_result_type sync_results_q[$];

   logic [63:0] off_acc, per_acc, sol_res, sol_mod;
   logic        bar_on, line_live, sol_have;
   status_type  err_code;
   int          lines_seen;

   function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (a != 0) begin
         t = b % a;
         b = a;
         a = t;
      end
      return b;
   endfunction

   function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [63:0] r;
      r = 0;
      while (b != 0) begin
         if (b[0]) begin
            r = r + a;
            if (r >= m) r = r - m;
         end
         a = a + a;
         if (a >= m) a = a - m;
         b = b >> 1;
      end
      return r;
   endfunction

   function automatic logic [63:0] inverse_mod(logic [63:0] a, logic [63:0] n);
      longint      t0, t1, tn;
      logic [63:0] r0, r1, q, rn;
      t0 = 0;
      t1 = 1;
      r0 = n;
      if (n <= 1) return 0;
      r1 = a % n;
      while (r1 != 0) begin
         q  = r0 / r1;
         rn = r0 - q * r1;
         tn = t0 - longint'(q) * t1;
         r0 = r1;
         r1 = rn;
         t0 = t1;
         t1 = tn;
      end
      if (t0 < 0) return n - 64'(-t0);
      return 64'(t0);
   endfunction

   task automatic clear_state();
      off_acc = 0; per_acc = 0; sol_res = 0; sol_mod = 0;
      bar_on = 0; line_live = 0; sol_have = 0;
      err_code = ST_OK; lines_seen = 0;
   endtask

   // generalized crt step of one congruence into the running solution
   task automatic merge_congruence(logic [63:0] r2, logic [63:0] m2);
      logic [63:0] g, m1g, n, r1m, d, k;
      g = gcd64(sol_mod, m2);
      if (g == 0) g = 1;
      if (sol_res % g != r2 % g) begin
         err_code = ST_UNREACH;
         return;
      end
      m1g = sol_mod / g;
      if (m1g > VMAX / m2) begin
         err_code = ST_OVF;
         return;
      end
      n   = m2 / g;
      r1m = sol_res % m2;
      d   = (r2 >= r1m) ? r2 - r1m : r2 + (m2 - r1m);
      d   = (d / g) % n;
      k   = mul_mod(d, inverse_mod(m1g % n, n), n);
      sol_res = sol_res + sol_mod * k;
      sol_mod = m1g * m2;
   endtask

   task automatic close_line();
      logic [63:0] per, off;
      per = per_acc;
      off = off_acc;
      off_acc = 0; per_acc = 0; bar_on = 0; line_live = 0;
      if (per == 0) begin
         err_code = ST_BAD;
         return;
      end
      if (lines_seen < 2) lines_seen++;
      if (per < 2) return;
      if (!sol_have) begin
         sol_res  = off % per;
         sol_mod  = per;
         sol_have = 1;
      end else begin
         merge_congruence(off % per, per);
      end
   endtask

   task automatic predict_beat(logic [7:0] ch, logic end_stream);
      sync_result_type exp_r;
      logic [63:0]     v;
      if (end_stream) begin
         if (err_code == ST_OK && line_live) close_line();
         exp_r.st   = err_code;
         exp_r.when = 0;
         if (exp_r.st == ST_OK && lines_seen < 2) exp_r.st = ST_BAD;
         if (exp_r.st == ST_OK && sol_have && sol_mod != 0)
            exp_r.when = SYNC_BITS'(sol_res % sol_mod);
         sync_results_q.push_back(exp_r);
         clear_state();
         return;
      end
      if (err_code != ST_OK) return;
      if (ch == CH_NL) begin
         close_line();
         return;
      end
      line_live = 1;
      if (ch == CH_BAR) begin
         if (bar_on) begin
            err_code = ST_BAD;
            return;
         end
         bar_on  = 1;
         per_acc = per_acc + off_acc;
         if (per_acc > VMAX) err_code = ST_OVF;
      end else if (ch >= CH_A && ch <= CH_Z) begin
         v = 64'd1 << (ch - CH_A);
         if (bar_on) begin
            if (per_acc > VMAX - v) err_code = ST_OVF;
            else per_acc = per_acc + v;
         end else begin
            if (off_acc > VMAX - v) err_code = ST_OVF;
            else off_acc = off_acc + v;
         end
      end else begin
         err_code = ST_BAD;
      end
   endtask

   task automatic report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
      clear_state();
   end

   assign pending = sync_results_q.size();

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         sync_results_q.delete();
      end else begin
         if (req_valid && !req_stall) predict_beat(req_ch, req_end_stream);
         if (rsp_valid && !rsp_stall) begin
            if (sync_results_q.size() == 0) begin
               report($sformatf("result beat with nothing expected (status %0d)",
                                rsp_status));
            end else begin
               sync_result_type e;
               e = sync_results_q.pop_front();
               status_seen[e.st]++;
               if (rsp_status != e.st)
                  report($sformatf("status %0d, expected %0d", rsp_status, e.st));
               if (rsp_sync_time != e.when)
                  report($sformatf("sync_time %0d, expected %0d",
                                   rsp_sync_time, e.when));
            end
         end
      end
   end

endmodule

// ===== tb/crt_congruence_sync_core_tb.sv =====
`timescale 1ns / 1ps
module crt_congruence_sync_core_tb;
   import crtcs_pkg::*;

   localparam int CYCLE_LIMIT = 16000000;
   localparam int RAND_ITEMS  = 930;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [7:0]           req_ch;
   logic                 req_end_stream;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [1:0]           rsp_status;
   logic [SYNC_BITS-1:0] rsp_sync_time;

   int fail_count, pending;
   int status_seen [4];
   int send_idle_pct, rsp_stall_pct, hold_cycles;
   int beats_sent, streams_sent, cycle_count;

   crt_congruence_sync_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_ch(req_ch), .req_end_stream(req_end_stream),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_sync_time(rsp_sync_time)
   );

   crt_congruence_sync_core_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_ch(req_ch), .req_end_stream(req_end_stream),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_sync_time(rsp_sync_time),
      .fail_count(fail_count), .pending(pending), .status_seen(status_seen)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // watchdog: a hang anywhere ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending);
         $display("crt_congruence_sync_core_tb: FAIL");
         $finish;
      end
   end

   // receiver side: random stall, or a long counted hold-off when requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // one beat: random idle gap, then hold valid until the block takes it
   task automatic send_beat(logic [7:0] ch, logic end_stream);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid      = 1'b0;
         req_ch         = 8'($urandom);
         req_end_stream = 1'($urandom);
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_ch         = ch;
      req_end_stream = end_stream;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
      beats_sent++;
      if (end_stream) streams_sent++;
   endtask

   // a whole stream of characters followed by the end beat
   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
      send_beat(8'($urandom), 1'b1);
   endtask

   task automatic wait_drained();
      while (pending != 0) @(negedge clock);
   endtask

   // letters mostly low so merges stay short, sometimes any letter
   function automatic logic [7:0] pick_letter();
      if ($urandom_range(9) == 0) return CH_A + 8'($urandom_range(25));
      return CH_A + 8'($urandom_range(5));
   endfunction

   task automatic send_random_stream();
      int nlines;
      if ($urandom_range(99) < 85) begin
         // well-formed lines with random content, a few broken ones mixed in
         nlines = $urandom_range(1, 4);
         for (int l = 0; l < nlines; l++) begin
            repeat ($urandom_range(3)) send_beat(pick_letter(), 1'b0);
            if ($urandom_range(19) != 0) send_beat(CH_BAR, 1'b0);
            repeat ($urandom_range(3)) send_beat(pick_letter(), 1'b0);
            if ($urandom_range(29) == 0) send_beat(CH_BAR, 1'b0);
            if ($urandom_range(29) == 0) send_beat(8'($urandom), 1'b0);
            if (l != nlines - 1 || $urandom_range(3) != 0) send_beat(CH_NL, 1'b0);
         end
      end else begin
         // raw byte noise covering every bit of ch
         repeat ($urandom_range(1, 8)) send_beat(8'($urandom), 1'b0);
      end
      send_beat(8'($urandom), 1'b1);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_ch         = 8'h00;
      req_end_stream = 1'b0;
      rsp_stall      = 1'b0;
      hold_cycles    = 0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      beats_sent     = 0;
      streams_sent   = 0;
      cycle_count    = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty stream, too few lines, simple merge
      send_text("");
      send_text("b|a\n");
      send_text("b|a\nab|b\n");
      wait_drained();
      // bad symbol, second bar, zero period, period one skipped
      send_text("a|b\nA|b\n");
      send_text("a|b|c\n|b\n");
      send_text("ab\n|b\n");
      send_text("|a\n|b\nb|b");
      // unreachable, modulus overflow with huge coprime periods
      send_text("|b\na|a\n");
      send_text("|za\n|zab\n|zac\n");
      // line left open at end, high bit bytes and extreme ch values
      send_text("a|c\nb|d");
      send_text({8'hff, "\n"});
      send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b1);

      // random phases: clean, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 19 : 57) : 0;
         rsp_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 19 : 57) : 0;
         if (ph == 2) begin
            // long hold-off while streams keep coming: the first result sits
            // in the output register, so the next end beat backs up the input
            hold_cycles = 3000;
            send_text("");
            send_text("b|a\n");
            repeat (2) send_random_stream();
         end
         while (beats_sent < (ph + 1) * RAND_ITEMS / 4) send_random_stream();
         if (ph == 1) wait_drained();
      end

      wait_drained();
      repeat (200) @(posedge clock);
      $display("%0d beats in %0d streams; results ok %0d, bad %0d, unreachable %0d, overflow %0d",
               beats_sent, streams_sent, status_seen[0], status_seen[1],
               status_seen[2], status_seen[3]);
      if (fail_count == 0 && pending == 0) begin
         $display("crt_congruence_sync_core_tb: PASS");
      end else begin
         $display("crt_congruence_sync_core_tb: FAIL");
      end
      $finish;
   end

endmodule
